[hw/rtl/pd_pkg.sv]
// shared types, constants and helpers for the percent decoder
`default_nettype none

package pd_pkg;

  // character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_F    = 8'h66;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLUS_AS_SPACE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRICT_MODE   = 1'd1;

  // most results a single byte can cause
  localparam int MAX_RES = 3;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_UNTERM  = 2'd1,
    ERR_BAD_HEX = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_PCT   = 2'd1,
    HELD_DIGIT = 2'd2
  } held_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
    err_t       error_code;
  } res_t;

  // all results caused by one byte, in order from index 0
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]   n;
  } grp_t;

  function automatic logic is_hex(logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE) ||
           (c >= CH_LO_A && c <= CH_LO_F) ||
           (c >= CH_UP_A && c <= CH_UP_F);
  endfunction

  // nibble value of a hex digit, zero for anything else
  function automatic logic [3:0] hex_nib(logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      v = c - CH_ZERO;
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      v = c - CH_LO_A + 8'd10;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      v = c - CH_UP_A + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pd_channels.sv]
// stream interfaces for the encoded byte input and the decoded result output
`default_nettype none

interface pd_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface pd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;
  logic [1:0] error_code;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  output error_code, input ready);
  modport sink (input valid, input out_byte, input run_last, input string_end,
                input error_code, output ready);
endinterface

`default_nettype wire

[hw/rtl/pd_step.sv]
// decode logic for one byte: result group and next escape state
`default_nettype none

module pd_step (
  input  wire logic [7:0]    in_byte,
  input  wire logic          eos,
  input  wire pd_pkg::held_t held,
  input  wire logic [7:0]    held_digit_byte,
  input  wire logic          discarding,
  input  wire logic          plus_as_space,
  input  wire logic          strict_mode,
  output pd_pkg::grp_t       grp,
  output pd_pkg::held_t      held_next,
  output logic [7:0]         held_digit_byte_next,
  output logic               discarding_next
);

  // effect of a byte seen with nothing held
  typedef struct packed {
    logic       emit;
    logic [7:0] val;
    logic       hold;
    logic       fail;
  } plain_t;

  function automatic plain_t plain_fn(logic [7:0] b, logic e, logic plus_sp, logic strict);
    plain_t p;
    p = '0;
    if (b == pd_pkg::CH_PERCENT) begin
      if (!e) begin
        p.hold = 1'b1;
      end else if (strict) begin
        p.fail = 1'b1;
      end else begin
        p.emit = 1'b1;
        p.val  = pd_pkg::CH_PERCENT;
      end
    end else if (plus_sp && b == pd_pkg::CH_PLUS) begin
      p.emit = 1'b1;
      p.val  = pd_pkg::CH_SPACE;
    end else begin
      p.emit = 1'b1;
      p.val  = b;
    end
    return p;
  endfunction

  plain_t                   pl;
  logic [pd_pkg::CNT_W-1:0] k;
  logic                     err;

  always_comb begin
    grp                  = '0;
    k                    = '0;
    err                  = 1'b0;
    held_next            = pd_pkg::HELD_NONE;
    held_digit_byte_next = held_digit_byte;
    discarding_next      = discarding;
    pl                   = plain_fn(in_byte, eos, plus_as_space, strict_mode);

    if (discarding) begin
      // drop the rest of a failed string
      if (eos) begin
        discarding_next = 1'b0;
      end
    end else begin
      unique case (held)
        pd_pkg::HELD_PCT: begin
          if (eos) begin
            if (strict_mode) begin
              grp.res[k].error_code = pd_pkg::ERR_UNTERM;
              k = k + 1'b1;
              err = 1'b1;
            end else begin
              grp.res[k].out_byte = pd_pkg::CH_PERCENT;
              k = k + 1'b1;
              grp.res[k].out_byte = in_byte;
              k = k + 1'b1;
            end
          end else if (pd_pkg::is_hex(in_byte)) begin
            held_next            = pd_pkg::HELD_DIGIT;
            held_digit_byte_next = in_byte;
          end else if (strict_mode) begin
            grp.res[k].error_code = pd_pkg::ERR_BAD_HEX;
            k = k + 1'b1;
            err = 1'b1;
            discarding_next = 1'b1;
          end else begin
            grp.res[k].out_byte = pd_pkg::CH_PERCENT;
            k = k + 1'b1;
            pl = plain_fn(in_byte, 1'b0, plus_as_space, strict_mode);
            if (pl.hold) begin
              held_next = pd_pkg::HELD_PCT;
            end
            if (pl.emit) begin
              grp.res[k].out_byte = pl.val;
              k = k + 1'b1;
            end
          end
        end
        pd_pkg::HELD_DIGIT: begin
          if (pd_pkg::is_hex(in_byte)) begin
            grp.res[k].out_byte = {pd_pkg::hex_nib(held_digit_byte),
                                   pd_pkg::hex_nib(in_byte)};
            k = k + 1'b1;
          end else if (strict_mode) begin
            grp.res[k].error_code = pd_pkg::ERR_BAD_HEX;
            k = k + 1'b1;
            err = 1'b1;
            discarding_next = !eos;
          end else begin
            grp.res[k].out_byte = pd_pkg::CH_PERCENT;
            k = k + 1'b1;
            grp.res[k].out_byte = held_digit_byte;
            k = k + 1'b1;
            if (pl.hold) begin
              held_next = pd_pkg::HELD_PCT;
            end
            if (pl.emit) begin
              grp.res[k].out_byte = pl.val;
              k = k + 1'b1;
            end
          end
        end
        default: begin
          if (pl.hold) begin
            held_next = pd_pkg::HELD_PCT;
          end
          if (pl.emit) begin
            grp.res[k].out_byte = pl.val;
            k = k + 1'b1;
          end
          if (pl.fail) begin
            grp.res[k].error_code = pd_pkg::ERR_UNTERM;
            k = k + 1'b1;
            err = 1'b1;
          end
        end
      endcase
    end

    // mark the last result of this byte, and the string end
    if (k != '0) begin
      grp.res[k - 1'b1].run_last   = 1'b1;
      grp.res[k - 1'b1].string_end = eos || err;
    end
    grp.n = k;
  end

endmodule

`default_nettype wire

[hw/rtl/pd_res_queue.sv]
// result register: holds one result group and hands it out one result a cycle while ready is high
`default_nettype none

module pd_res_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire pd_pkg::grp_t grp,
  output logic              free,
  output logic              valid,
  output pd_pkg::res_t      cur,
  input  wire logic         ready
);

  pd_pkg::res_t [pd_pkg::MAX_RES-1:0] res;
  logic [pd_pkg::CNT_W-1:0]           cnt;
  logic [pd_pkg::CNT_W-1:0]           idx;
  logic                               pop;

  assign valid = (cnt != '0);
  assign pop   = valid && ready;
  assign free  = (cnt == '0) || (cnt == pd_pkg::CNT_W'(1) && ready);

  always_comb begin
    case (idx)
      pd_pkg::CNT_W'(1): cur = res[1];
      pd_pkg::CNT_W'(2): cur = res[2];
      default:           cur = res[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      idx <= '0;
    end else if (load && free && grp.n != '0) begin
      cnt <= grp.n;
      idx <= '0;
    end else if (pop) begin
      cnt <= cnt - 1'b1;
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      res <= grp.res;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/percent_decoder.sv]
// top level of the streaming uri percent decoder
`default_nettype none

// Streaming percent decoder. One byte of an encoded string is taken per
// transaction on item, with end_of_string on the string's last byte; decoded
// bytes leave one per transaction on result, with run_last on the last result
// of each input byte and string_end on the final result of the string. A
// %XX escape (either case) gives one byte; '%' and the first digit are held
// inside and give nothing until the escape resolves. Strict mode turns a
// malformed escape into one error result that ends the string, then drops
// input up to the string's next end byte. Rate: one byte per cycle while
// result.ready is high and each byte gives at most one result; a byte giving
// two or three results (a malformed escape in lenient mode) holds the result
// register until its last result is taken, and the input register waits.
// Bytes pass through the input register, then the result register. The user
// must write configuration only while idle; the block does not enforce this.
module percent_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  pd_item_if.sink                            item,
  pd_result_if.source                        result,
  input  wire logic                          cfg_we,
  input  wire logic [pd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pd_pkg::CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic plus_as_space;
  logic strict_mode;

  // input register
  logic       iq_valid;
  logic [7:0] iq_byte;
  logic       iq_eos;

  // escape state, updated as the held item is decoded
  pd_pkg::held_t held;
  pd_pkg::held_t held_next;
  logic [7:0]    held_digit_byte;
  logic [7:0]    held_digit_byte_next;
  logic          discarding;
  logic          discarding_next;

  pd_pkg::grp_t grp;
  pd_pkg::res_t cur;
  logic         free;
  logic         move;

  // decoded item goes into the result register once it is free
  assign move       = iq_valid && free;
  assign item.ready = !iq_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      plus_as_space <= 1'b0;
      strict_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pd_pkg::CFG_PLUS_AS_SPACE: plus_as_space <= cfg_data[0];
        pd_pkg::CFG_STRICT_MODE:   strict_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid <= 1'b0;
    end else if (item.ready) begin
      iq_valid <= item.valid;
    end
  end

  // payload of the input register
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      iq_byte <= item.in_byte;
      iq_eos  <= item.end_of_string;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held            <= pd_pkg::HELD_NONE;
      held_digit_byte <= 8'd0;
      discarding      <= 1'b0;
    end else if (move) begin
      held            <= held_next;
      held_digit_byte <= held_digit_byte_next;
      discarding      <= discarding_next;
    end
  end

  pd_step u_step (
    .in_byte              (iq_byte),
    .eos                  (iq_eos),
    .held                 (held),
    .held_digit_byte      (held_digit_byte),
    .discarding           (discarding),
    .plus_as_space        (plus_as_space),
    .strict_mode          (strict_mode),
    .grp                  (grp),
    .held_next            (held_next),
    .held_digit_byte_next (held_digit_byte_next),
    .discarding_next      (discarding_next)
  );

  pd_res_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .load  (move),
    .grp   (grp),
    .free  (free),
    .valid (result.valid),
    .cur   (cur),
    .ready (result.ready)
  );

  assign result.out_byte   = cur.out_byte;
  assign result.run_last   = cur.run_last;
  assign result.string_end = cur.string_end;
  assign result.error_code = cur.error_code;

`ifndef SYNTHESIS
  // nothing is held while a failed string is dropped
  a_disc_no_held: assert property (@(posedge clk) disable iff (rst)
    !(discarding && held != pd_pkg::HELD_NONE))
    else $error("escape held while discarding");

  // a string end leaves no held escape and no discard pending
  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    move && iq_eos |=> held == pd_pkg::HELD_NONE && !discarding)
    else $error("state left over after string end");

  // the rest of a result group follows without a gap
  a_group_contig: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready && !result.run_last |=> result.valid)
    else $error("gap inside a result group");

  // an error result is always the last one of its string
  a_err_ends: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.error_code != pd_pkg::ERR_NONE |->
      result.string_end && result.run_last)
    else $error("error result does not end the string");
`endif

endmodule

`default_nettype wire
